// ===== sv/cfr_pkg.sv =====
// Shared types, codes and constant byte patterns for the CFI record emitter.
package cfr_pkg;

  localparam logic [1:0] CMD_CIE  = 2'd0;
  localparam logic [1:0] CMD_FDE  = 2'd1;
  localparam logic [1:0] CMD_TERM = 2'd2;

  localparam logic [1:0] KIND_CIE  = 2'd0;
  localparam logic [1:0] KIND_FDE  = 2'd1;
  localparam logic [1:0] KIND_TERM = 2'd2;

  localparam logic [1:0] MODE_NONE      = 2'd0;
  localparam logic [1:0] MODE_FRAMELESS = 2'd1;
  localparam logic [1:0] MODE_FRAME     = 2'd2;

  localparam logic [31:0] ENC_MODE_MASK  = 32'h0F00_0000;
  localparam logic [31:0] ENC_FRAMELESS  = 32'h0200_0000;
  localparam logic [31:0] ENC_FRAME      = 32'h0400_0000;

  localparam logic [7:0] DW_DEF_CFA    = 8'h0c;
  localparam logic [7:0] DW_OFFSET     = 8'h80;
  localparam logic [7:0] DW_OFFSET_EXT = 8'h05;
  localparam logic [7:0] CFA_REG_SP    = 8'h1f;

  // def_cfa fp,16 ; offset lr,1 ; offset fp,2
  localparam logic [63:0] FRAME_PROLOGUE = 64'h0002_9d01_9e10_1d0c;

  typedef struct packed {
    logic [1:0]  kind;
    logic        flag;     // CIE: zPLR form, FDE: LSDA present
    logic        status;
    logic [3:0]  words;
    logic [2:0]  pad;
    logic [1:0]  mode;
    logic [23:0] uleb;
    logic [1:0]  ulen;
    logic [4:0]  xmask;
    logic [3:0]  dmask;
    logic [63:0] hdr;
    logic [63:0] pc;
    logic [31:0] flen;
    logic [63:0] data;     // CIE: personality, FDE: LSDA
  } desc_t;

  // Words of a CIE, zR or zPLR form.
  function automatic logic [63:0] cie_word(logic [1:0] k, logic zplr, logic [63:0] pers);
    logic [63:0] w;
    w = '0;
    if (zplr) begin
      case (k)
        2'd0:    w = 64'h0000_0000_0000_001c;
        2'd1:    w = 64'h7801_0052_4c50_7a01;
        2'd2:    w = {pers[39:0], 8'h00, 8'h0b, 8'h1e};
        default: w = {8'h00, CFA_REG_SP, DW_DEF_CFA, 8'h00, 8'h00, pers[63:40]};
      endcase
    end else begin
      case (k)
        2'd0:    w = 64'h0000_0000_0000_0014;
        2'd1:    w = 64'h011e_7801_0052_7a01;
        default: w = 64'h0000_0000_001f_0c00;
      endcase
    end
    return w;
  endfunction

endpackage

// ===== sv/cfr_ifs.sv =====
// Valid/ready channel interfaces for commands and stream words.
interface cfi_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] encoding;
  logic [63:0] func_address;
  logic [31:0] func_length;
  logic [63:0] lsda_address;
  logic [63:0] personality_address;
  modport source (output valid, command, encoding, func_address, func_length,
                  lsda_address, personality_address, input ready);
  modport sink (input valid, command, encoding, func_address, func_length,
                lsda_address, personality_address, output ready);
endinterface

interface cfi_word_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last;
  logic        status;
  modport source (output valid, data_word, byte_count, last, status, input ready);
  modport sink (input valid, data_word, byte_count, last, status, output ready);
endinterface

// ===== sv/cfr_front.sv =====
// Front end: accepts commands, tracks stream offsets, sizes each record.
module cfr_front
  import cfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  cfi_cmd_if.sink     cmd,
  input  logic        full,
  output logic        push,
  output desc_t       push_data
);

  logic [31:0] stream_offset;
  logic [31:0] cie_start_offset;
  logic        cie_has_personality;

  logic        accept;
  logic        pers_nz;
  logic [31:0] mode;
  logic [15:0] fsize;
  logic [2:0]  pcx, pcd;
  logic [6:0]  rules, total, padded;
  logic [31:0] body, cie_delta;

  assign cmd.ready = !full;
  assign accept    = cmd.valid && !full;
  assign pers_nz   = cmd.personality_address != 64'd0;
  assign mode      = cmd.encoding & ENC_MODE_MASK;
  assign fsize     = {cmd.encoding[23:12], 4'b0000};
  assign pcx       = 3'($countones(cmd.encoding[4:0]));
  assign pcd       = 3'($countones(cmd.encoding[11:8]));
  assign cie_delta = stream_offset + 32'd4 - cie_start_offset;

  always_comb begin
    push_data = '0;
    push      = 1'b0;
    rules     = '0;
    total     = '0;
    padded    = '0;
    body      = '0;
    push_data.pc   = cmd.func_address;
    push_data.flen = cmd.func_length;
    case (cmd.command)
      CMD_CIE: begin
        push            = accept;
        push_data.kind  = KIND_CIE;
        push_data.flag  = pers_nz;
        push_data.words = pers_nz ? 4'd4 : 4'd3;
        push_data.data  = cmd.personality_address;
      end
      CMD_FDE: begin
        push            = accept;
        push_data.kind  = KIND_FDE;
        push_data.flag  = cie_has_personality;
        push_data.data  = cmd.lsda_address;
        push_data.xmask = cmd.encoding[4:0];
        push_data.dmask = cmd.encoding[11:8];
        // uleb128 of the frameless stack size
        push_data.uleb[7:0]   = {fsize >= 16'd128, fsize[6:0]};
        push_data.uleb[15:8]  = {fsize >= 16'd16384, fsize[13:7]};
        push_data.uleb[23:16] = {6'b0, fsize[15:14]};
        push_data.ulen = (fsize < 16'd128) ? 2'd1 : ((fsize < 16'd16384) ? 2'd2 : 2'd3);
        if (mode == ENC_FRAMELESS) begin
          push_data.mode = MODE_FRAMELESS;
          rules = 7'd2 + {5'b0, push_data.ulen};
        end else if (mode == ENC_FRAME) begin
          push_data.mode = MODE_FRAME;
          rules = 7'd7 + {2'b0, pcx, 2'b00} + {2'b0, pcd, 2'b00} + {3'b0, pcd, 1'b0};
        end else begin
          push_data.mode   = MODE_NONE;
          push_data.status = 1'b1;
        end
        total  = (cie_has_personality ? 7'd33 : 7'd25) + rules;
        padded = (total + 7'd7) & 7'h78;
        body   = {25'b0, padded} - 32'd4;
        push_data.pad   = 3'(padded - total);
        push_data.words = padded[6:3];
        push_data.hdr   = {cie_delta, body};
      end
      CMD_TERM: begin
        push            = accept;
        push_data.kind  = KIND_TERM;
        push_data.words = 4'd1;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_offset       <= '0;
      cie_start_offset    <= '0;
      cie_has_personality <= 1'b0;
    end else if (accept) begin
      case (cmd.command)
        CMD_CIE: begin
          cie_start_offset    <= stream_offset;
          cie_has_personality <= pers_nz;
          stream_offset       <= stream_offset + (pers_nz ? 32'd32 : 32'd24);
        end
        CMD_FDE:  stream_offset <= stream_offset + {25'b0, padded};
        CMD_TERM: stream_offset <= stream_offset + 32'd4;
        default:  stream_offset <= stream_offset;
      endcase
    end
  end

endmodule

// ===== sv/cfr_queue.sv =====
// Small descriptor queue between front and back ends.
module cfr_queue
  import cfr_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  input  logic  pop,
  output desc_t pop_data,
  output logic  full,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t          mem [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CW'(push && !full) - CW'(pop && !empty);
    end
  end

endmodule

// ===== sv/cfr_back.sv =====
// Back end: walks record segments, packs bytes into words, drives output.
module cfr_back
  import cfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      empty,
  input  desc_t     q_data,
  output logic      pop,
  cfi_word_if.source word
);

  localparam logic [3:0] P_IDLE = 4'd0;
  localparam logic [3:0] P_CIE  = 4'd1;
  localparam logic [3:0] P_HDR  = 4'd2;
  localparam logic [3:0] P_PC   = 4'd3;
  localparam logic [3:0] P_LEN  = 4'd4;
  localparam logic [3:0] P_AUG  = 4'd5;
  localparam logic [3:0] P_LSDA = 4'd6;
  localparam logic [3:0] P_RULE = 4'd7;
  localparam logic [3:0] P_XP   = 4'd8;
  localparam logic [3:0] P_DP   = 4'd9;
  localparam logic [3:0] P_PAD  = 4'd10;
  localparam logic [3:0] P_TERM = 4'd11;

  logic [3:0]  phase, phase_next;
  desc_t       cur;
  logic [4:0]  xm, xm_next;
  logic [3:0]  dm, dm_next;
  logic [4:0]  slot, slot_next;
  logic [63:0] acc;
  logic [2:0]  cnt;
  logic [3:0]  wc;

  logic         adv, step, emit;
  logic [63:0]  seg;
  logic [3:0]   slen, total;
  logic [127:0] wide;
  logic [2:0]   xi;
  logic [1:0]   di;
  logic [5:0]   xr;
  logic [6:0]   dr;
  logic [7:0]   s0, s1;

  assign adv  = !word.valid || word.ready;
  assign step = adv && phase != P_IDLE;
  assign pop  = phase == P_IDLE && !empty;
  assign s0   = {3'b0, slot};
  assign s1   = {3'b0, slot + 5'd1};

  always_comb begin
    xi = '0;
    for (int i = 4; i >= 0; i--) if (xm[i]) xi = 3'(i);
    di = '0;
    for (int i = 3; i >= 0; i--) if (dm[i]) di = 2'(i);
  end
  assign xr = 6'd19 + {2'b0, xi, 1'b0};
  assign dr = 7'd72 + {4'b0, di, 1'b0};

  always_comb begin
    seg        = '0;
    slen       = '0;
    phase_next = phase;
    xm_next    = xm;
    dm_next    = dm;
    slot_next  = slot;
    case (phase)
      P_CIE: begin
        seg  = cie_word(wc[1:0], cur.flag, cur.data);
        slen = 4'd8;
        if (wc + 4'd1 == cur.words) phase_next = P_IDLE;
      end
      P_HDR: begin seg = cur.hdr;           slen = 4'd8; phase_next = P_PC;  end
      P_PC:  begin seg = cur.pc;            slen = 4'd8; phase_next = P_LEN; end
      P_LEN: begin seg = {32'b0, cur.flen}; slen = 4'd8; phase_next = P_AUG; end
      P_AUG: begin
        seg        = cur.flag ? 64'd8 : 64'd0;
        slen       = 4'd1;
        phase_next = cur.flag ? P_LSDA : P_RULE;
      end
      P_LSDA: begin seg = cur.data; slen = 4'd8; phase_next = P_RULE; end
      P_RULE: begin
        case (cur.mode)
          MODE_FRAMELESS: begin
            seg        = {24'b0, cur.uleb, CFA_REG_SP, DW_DEF_CFA};
            slen       = 4'd2 + {2'b0, cur.ulen};
            phase_next = P_PAD;
          end
          MODE_FRAME: begin
            seg        = FRAME_PROLOGUE;
            slen       = 4'd7;
            phase_next = (xm != '0) ? P_XP : ((dm != '0) ? P_DP : P_PAD);
          end
          default: phase_next = P_PAD;
        endcase
      end
      P_XP: begin
        seg  = {32'b0, s1, DW_OFFSET | {2'b0, xr + 6'd1}, s0, DW_OFFSET | {2'b0, xr}};
        slen = 4'd4;
        xm_next        = xm & ~(5'd1 << xi);
        slot_next      = slot + 5'd2;
        phase_next     = (xm_next != '0) ? P_XP : ((dm != '0) ? P_DP : P_PAD);
      end
      P_DP: begin
        seg  = {16'b0, s1, {1'b0, dr + 7'd1}, DW_OFFSET_EXT, s0, {1'b0, dr}, DW_OFFSET_EXT};
        slen = 4'd6;
        dm_next    = dm & ~(4'd1 << di);
        slot_next  = slot + 5'd2;
        phase_next = (dm_next != '0) ? P_DP : P_PAD;
      end
      P_PAD: begin slen = {1'b0, cur.pad}; phase_next = P_IDLE; end
      P_TERM: phase_next = P_IDLE;
      default: phase_next = phase;
    endcase
  end

  // byte packer: at most one full word leaves per step
  assign total = {1'b0, cnt} + slen;
  assign wide  = {64'b0, acc} | ({64'b0, seg} << {cnt, 3'b000});
  assign emit  = step && (phase == P_TERM || total[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= P_IDLE;
      cnt        <= '0;
      acc        <= '0;
      wc         <= '0;
      word.valid <= 1'b0;
    end else begin
      if (pop) begin
        wc <= '0;
        case (q_data.kind)
          KIND_CIE:  phase <= P_CIE;
          KIND_FDE:  phase <= P_HDR;
          default:   phase <= P_TERM;
        endcase
      end else if (step) begin
        phase <= phase_next;
        if (phase != P_TERM) begin
          acc <= total[3] ? wide[127:64] : wide[63:0];
          cnt <= total[2:0];
        end
        if (emit) wc <= wc + 4'd1;
      end
      if (adv) word.valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= q_data;
      xm   <= q_data.xmask;
      dm   <= q_data.dmask;
      slot <= 5'd3;
    end else if (step) begin
      xm   <= xm_next;
      dm   <= dm_next;
      slot <= slot_next;
    end
    if (emit) begin
      word.data_word  <= (phase == P_TERM) ? 64'd0 : wide[63:0];
      word.byte_count <= (phase == P_TERM) ? 4'd4 : 4'd8;
      word.last       <= wc + 4'd1 == cur.words;
      word.status     <= cur.status;
    end
  end

endmodule

// ===== sv/cfi_record_emitter.sv =====
// Top level of the arm64 unwind-table CIE/FDE record emitter.
// A command is written to the queue at its accepting edge; once the back end is idle
//   the record is popped, and its first word is then registered in the output register.
// The back end handles one segment per cycle while the output is not stalled, and pops
//   a new record only after the segments of the last one are through.
// Reset (synchronous, rst high) clears offsets, CIE state, queue and output.
module cfi_record_emitter
  import cfr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  cfi_cmd_if.sink    cmd,
  cfi_word_if.source word
);

  // Front: each accepted transaction is classified and sized here, so the
  // record length and CIE back-distance are known before the first word.
  desc_t push_data, pop_data;
  logic  push, pop, full, empty;

  cfr_front u_front (
    .clk(clk), .rst(rst), .cmd(cmd), .full(full),
    .push(push), .push_data(push_data)
  );

  // Queue lets the front keep taking commands while the back is stalled.
  cfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .full(full), .empty(empty)
  );

  // Back: segment sequencer, byte packer and output register.
  cfr_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .q_data(pop_data),
    .pop(pop), .word(word)
  );

endmodule

// ===== sv/cfr_checker.sv =====
// Port-level checker for the record emitter, bound to the top level.
module cfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic [63:0] data_word,
  input logic [3:0]  byte_count,
  input logic        last,
  input logic        status
);

  a_term_word: assert property (@(posedge clk) disable iff (rst)
    valid && byte_count == 4'd4 |-> data_word == 64'd0 && last && !status)
    else $error("terminator word malformed");

  a_count: assert property (@(posedge clk) disable iff (rst)
    valid |-> (byte_count == 4'd4 || byte_count == 4'd8))
    else $error("bad byte_count");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(data_word) && $stable(last))
    else $error("stalled word changed");

  a_reset: assert property (@(posedge clk) rst |=> !valid)
    else $error("output valid after reset");

endmodule

bind cfi_record_emitter cfr_checker u_cfr_checker (
  .clk(clk), .rst(rst), .valid(word.valid), .ready(word.ready),
  .data_word(word.data_word), .byte_count(word.byte_count),
  .last(word.last), .status(word.status)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for cfi_record_emitter: directed table, random commands, predictor.
module tb_top;
  import cfr_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]  command;
    logic [31:0] enc;
    logic [63:0] pc;
    logic [31:0] flen;
    logic [63:0] lsda;
    logic [63:0] pers;
    bit          chk;   // first word typed in below
    logic [63:0] w0;
  } cmd_row_t;

  typedef struct {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
    logic        status;
  } out_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   errors = 0;
  bit   calm = 1'b0;

  cfi_cmd_if  cmd();
  cfi_word_if word();

  cfi_record_emitter u_dut (.clk(clk), .rst(rst), .cmd(cmd.sink), .word(word.source));

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] stream_ofs;
  logic [31:0] cie_ofs;
  logic        cie_zplr;
  logic [7:0]  rec_bytes [0:95];
  int          rec_len;
  out_word_t   expected_words[$];

  function automatic void put_byte(logic [7:0] b);
    if (rec_len < 96) rec_bytes[rec_len] = b;
    rec_len++;
  endfunction

  function automatic void put_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) put_byte(v[8*i +: 8]);
  endfunction

  function automatic void put_leb(logic [63:0] v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[7] = 1'b1;
      put_byte(b);
    end while (v != 0);
  endfunction

  // Returns 1 when the unwind mode is supported.
  function automatic bit put_cfa_rules(logic [31:0] enc);
    logic [31:0] mode;
    logic [7:0]  slot;
    logic [7:0]  r;
    mode = enc & ENC_MODE_MASK;
    slot = 8'd3;
    if (mode == ENC_FRAMELESS) begin
      put_byte(DW_DEF_CFA); put_leb(64'd31);
      put_leb(64'(enc[23:12]) * 64'd16);
      return 1'b1;
    end
    if (mode != ENC_FRAME) return 1'b0;
    put_byte(DW_DEF_CFA); put_leb(64'd29); put_leb(64'd16);
    put_byte(DW_OFFSET | 8'd30); put_leb(64'd1);
    put_byte(DW_OFFSET | 8'd29); put_leb(64'd2);
    for (int i = 0; i < 5; i++)
      if (enc[i]) begin
        r = 8'(19 + 2*i);
        put_byte(DW_OFFSET | r); put_leb(64'(slot)); slot++;
        put_byte(DW_OFFSET | (r + 8'd1)); put_leb(64'(slot)); slot++;
      end
    for (int i = 0; i < 4; i++)
      if (enc[8+i]) begin
        r = 8'(72 + 2*i);
        put_byte(DW_OFFSET_EXT); put_leb(64'(r)); put_leb(64'(slot)); slot++;
        put_byte(DW_OFFSET_EXT); put_leb(64'(r + 8'd1)); put_leb(64'(slot)); slot++;
      end
    return 1'b1;
  endfunction

  // Pads, patches the length and queues the words of the record.
  function automatic void close_record(logic st);
    logic [31:0] body;
    out_word_t   w;
    int          n;
    while (rec_len % 8 != 0) put_byte(8'h00);
    body = 32'(rec_len - 4);
    for (int k = 0; k < 4; k++) rec_bytes[k] = body[8*k +: 8];
    n = rec_len / 8;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 8; k++) w.data_word[8*k +: 8] = rec_bytes[(i*8 + k) % 96];
      w.byte_count = 4'd8;
      w.last       = (i == n - 1);
      w.status     = st;
      expected_words.push_back(w);
    end
    stream_ofs += 32'(rec_len);
  endfunction

  function automatic void predict_record(cmd_row_t c);
    out_word_t w;
    bit        ok;
    int        first;
    first = expected_words.size();
    rec_len = 0;
    for (int k = 0; k < 96; k++) rec_bytes[k] = 8'h00;
    case (c.command)
      CMD_CIE: begin
        cie_ofs  = stream_ofs;
        cie_zplr = (c.pers != 0);
        put_le(64'd0, 4); put_le(64'd0, 4); put_byte(8'd1);
        put_byte("z");
        if (cie_zplr) begin
          put_byte("P"); put_byte("L");
        end
        put_byte("R"); put_byte(8'h00);
        put_leb(64'd1); put_byte(8'h78); put_leb(64'd30);
        if (cie_zplr) begin
          put_leb(64'd11); put_byte(8'h00); put_le(c.pers, 8); put_byte(8'h00); put_byte(8'h00);
        end else begin
          put_leb(64'd1); put_byte(8'h00);
        end
        put_byte(DW_DEF_CFA); put_leb(64'd31); put_leb(64'd0);
        close_record(1'b0);
      end
      CMD_FDE: begin
        put_le(64'd0, 4);
        put_le(64'(stream_ofs + 32'd4 - cie_ofs), 4);
        put_le(c.pc, 8);
        put_le(64'(c.flen), 8);
        if (cie_zplr) begin
          put_leb(64'd8); put_le(c.lsda, 8);
        end else begin
          put_leb(64'd0);
        end
        ok = put_cfa_rules(c.enc);
        close_record(!ok);
      end
      CMD_TERM: begin
        w = '{64'd0, 4'd4, 1'b1, 1'b0};
        expected_words.push_back(w);
        stream_ofs += 32'd4;
      end
      default: ;  // unknown command: dropped
    endcase
    if (c.chk && expected_words.size() > first) expected_words[first].data_word = c.w0;
  endfunction

  // Reset, cycle limit.
  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && word.valid && word.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word %h", word.data_word);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (word.data_word !== e.data_word) begin
          $error("data_word exp %h got %h", e.data_word, word.data_word); errors++;
        end
        if (word.byte_count !== e.byte_count) begin
          $error("byte_count exp %0d got %0d", e.byte_count, word.byte_count); errors++;
        end
        if (word.last !== e.last) begin
          $error("last exp %0b got %0b", e.last, word.last); errors++;
        end
        if (word.status !== e.status) begin
          $error("status exp %0b got %0b", e.status, word.status); errors++;
        end
      end
    end
  end

  // Receiver: bursts of backpressure, stretches of none.
  initial begin
    word.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        word.ready = 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        word.ready = 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk);
      end
    end
  end

  // ready comes from registered state, so its value at a falling edge holds
  // through the next rising edge
  task automatic send(cmd_row_t c);
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      cmd.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    cmd.command             = c.command;
    cmd.encoding            = c.enc;
    cmd.func_address        = c.pc;
    cmd.func_length         = c.flen;
    cmd.lsda_address        = c.lsda;
    cmd.personality_address = c.pers;
    cmd.valid               = 1'b1;
    while (!cmd.ready) @(negedge clk);
    @(posedge clk);
    predict_record(c);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic cmd_row_t random_row();
    cmd_row_t c;
    int       pick;
    c = '{CMD_FDE, $urandom, rand64(), $urandom, rand64(), 64'd0, 1'b0, 64'd0};
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      c.command = CMD_CIE;
      if ($urandom_range(0, 1)) c.pers = rand64();
    end else if (pick < 15) c.command = CMD_TERM;
    else if (pick < 18) c.command = CMD_NONE;
    else if (pick < 24) ;  // raw encoding, mostly unsupported modes
    else begin
      // well-formed: frame or frameless, random pair bits and size
      c.enc[27:24] = $urandom_range(0, 1) ? 4'h4 : 4'h2;
    end
    if ($urandom_range(0, 7) == 0) c.lsda = 64'd0;
    return c;
  endfunction

  // Stimulus.
  initial begin
    cmd_row_t    dir_rows[$];
    logic [63:0] ones;
    int          waited;
    ones = '1;
    stream_ofs = '0; cie_ofs = '0; cie_zplr = 1'b0;
    cmd.valid = 1'b0; cmd.command = CMD_NONE; cmd.encoding = '0; cmd.func_address = '0;
    cmd.func_length = '0; cmd.lsda_address = '0; cmd.personality_address = '0;

    // FDE before any CIE, frameless with largest size
    dir_rows.push_back('{CMD_FDE, 32'h02FF_F000, ones, 32'hFFFF_FFFF, ones, 64'd0, 1'b0, 0});
    dir_rows.push_back('{CMD_TERM, 32'd0, 0, 0, 0, 0, 1'b1, 64'd0});
    // zR CIE: length 0x14, CIE id zero
    dir_rows.push_back('{CMD_CIE, 32'd0, 0, 0, 0, 64'd0, 1'b1, 64'h14});
    // frame with every x and d pair
    dir_rows.push_back('{CMD_FDE, 32'h0400_0F1F, 64'd0, 32'd0, ones, 64'd0, 1'b0, 0});
    dir_rows.push_back('{CMD_FDE, 32'h0400_0000, 64'h1000, 32'h40, 0, 0, 1'b0, 0});
    // unsupported modes
    dir_rows.push_back('{CMD_FDE, 32'h0000_0000, 64'h2000, 32'h10, 0, 0, 1'b0, 0});
    dir_rows.push_back('{CMD_FDE, 32'h0F00_0000, 64'h3000, 32'h10, 0, 0, 1'b0, 0});
    // zPLR CIE: length 0x1c
    dir_rows.push_back('{CMD_CIE, 32'd0, 0, 0, 0, ones, 1'b1, 64'h1c});
    // longest record: LSDA plus every pair
    dir_rows.push_back('{CMD_FDE, 32'h0400_0F1F, ones, 32'hFFFF_FFFF, ones, ones, 1'b0, 0});
    dir_rows.push_back('{CMD_FDE, 32'h0200_0000, 64'd0, 32'd0, 64'd0, 0, 1'b0, 0});
    dir_rows.push_back('{CMD_NONE, 32'hFFFF_FFFF, ones, 32'hFFFF_FFFF, ones, ones, 1'b0, 0});
    dir_rows.push_back('{CMD_CIE, 32'd0, 0, 0, 0, 64'd1, 1'b1, 64'h1c});
    dir_rows.push_back('{CMD_FDE, 32'hFFFF_FFFF, 64'h5, 32'h8, 64'h9, 0, 1'b0, 0});
    dir_rows.push_back('{CMD_FDE, 32'h0200_1000, 64'h5, 32'h8, 64'h9, 0, 1'b0, 0});
    dir_rows.push_back('{CMD_TERM, 32'd0, 0, 0, 0, 0, 1'b1, 64'd0});
    dir_rows.push_back('{CMD_CIE, 32'd0, 0, 0, 0, 64'd0, 1'b1, 64'h14});
    dir_rows.push_back('{CMD_FDE, 32'h0400_0155, 64'h7, 32'h9, 64'h0, 0, 1'b0, 0});

    @(negedge clk);
    while (rst) @(negedge clk);
    foreach (dir_rows[i]) send(dir_rows[i]);

    for (int n = 0; n < 370; n++) begin
      if (n == 320) calm = 1'b1;
      // hold off until the block has drained
      if (n == 150) begin
        @(negedge clk);
        cmd.valid = 1'b0;
        while (expected_words.size() != 0) @(negedge clk);
      end
      send(random_row());
    end
    @(negedge clk);
    cmd.valid = 1'b0;

    waited = 0;
    while (expected_words.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      if (expected_words.size() != 0) $error("%0d words never came", expected_words.size());
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/cfr_pkg.sv
sv/cfr_ifs.sv
sv/cfr_front.sv
sv/cfr_queue.sv
sv/cfr_back.sv
sv/cfi_record_emitter.sv
sv/cfr_checker.sv
sim/tb_top.sv
